// ===== src/swm_pkg.sv =====
// Shared constants and types for the sliding window median unit.
package swm_pkg;

   // Window geometry
   localparam int MAX_WINDOW = 8;
   localparam int SAMPLE_W   = 16;
   localparam int IDX_W      = $clog2(MAX_WINDOW);
   localparam int LEN_W      = $clog2(MAX_WINDOW + 1);

   // Register file
   localparam int CFG_LEN_W     = 4;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int WINDOW_LEN_RESET = 5;
   localparam logic CSR_IDX_WINDOW_LEN = 1'b0;

   // Probe that travels around the ring of cells during ranking
   typedef struct packed {
      logic                       active;
      logic [IDX_W-1:0]           idx;
      logic signed [SAMPLE_W-1:0] value;
   } probe_type;

   // Per-cycle control broadcast to every cell
   typedef struct packed {
      logic shift;
      logic load;
      logic count;
   } cell_ctl_type;

endpackage

// ===== src/sliding_window_median_unit.sv =====
// Sliding window median filter: top level with control and register port.
//
// Each request carries one signed 16-bit sample. The sample shifts into a
// row of MAX_WINDOW cells (oldest at cell 0) and one response returns the
// median of the newest window_len samples; even lengths give the floor of
// the mean of the two middle values. window_len is register 0 on the csr
// port (byte address 0); 0 acts as 1, values above MAX_WINDOW as MAX_WINDOW.
//
// Ranking: probes circulate around the ring of cells, one hop per cycle, and
// every cell counts the probes that sort below it. A request thus passes
// through a load state, a counting state in which the probes make a full
// round of the ring, and a select state, after which the median enters the
// output register. A new request is taken only once the unit is back in
// idle, so no new sample is taken while the last one is still ranked.
//
// The response sits in an output register; the next request is taken while
// it waits. If the receiver stalls, a finished median waits in the select
// state until the output register frees up, and no further request is taken.
// Synchronous reset clears the window to zeros, sets window_len to 5 and
// drops any pending response.
module sliding_window_median_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [swm_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [swm_pkg::SAMPLE_W-1:0]    rsp_median,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [swm_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [swm_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOAD  = 2'd1;
   localparam logic [1:0] ST_COUNT = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]                          state_ff, state_in;
   logic [swm_pkg::IDX_W-1:0]           step_ff, step_in;
   logic [swm_pkg::CFG_LEN_W-1:0]       window_len_ff;
   logic                                rsp_valid_ff;
   logic signed [swm_pkg::SAMPLE_W-1:0] rsp_median_ff;

   logic                                accept, out_free, csr_wr, csr_hit;
   logic [swm_pkg::LEN_W-1:0]           eff_len;
   logic [swm_pkg::IDX_W-1:0]           lo_rank, hi_rank;
   logic [swm_pkg::MAX_WINDOW-1:0]      active_set, active_cells;
   swm_pkg::cell_ctl_type               ctl;
   logic signed [swm_pkg::SAMPLE_W-1:0] samples [swm_pkg::MAX_WINDOW];
   swm_pkg::probe_type                  probes  [swm_pkg::MAX_WINDOW];
   logic [swm_pkg::IDX_W-1:0]           ranks   [swm_pkg::MAX_WINDOW];
   logic signed [swm_pkg::SAMPLE_W-1:0] median;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == swm_pkg::CSR_IDX_WINDOW_LEN);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {{(swm_pkg::CSR_DATA_W-swm_pkg::CFG_LEN_W){1'b0}},
                                  window_len_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= swm_pkg::CFG_LEN_W'(swm_pkg::WINDOW_LEN_RESET);
      end else if (csr_wr && csr_hit) begin
         window_len_ff <= csr_pwdata[swm_pkg::CFG_LEN_W-1:0];
      end
   end

   // Effective length and the two middle ranks
   always_comb begin
      if (window_len_ff == '0) begin
         eff_len = swm_pkg::LEN_W'(1);
      end else if (32'(window_len_ff) > swm_pkg::MAX_WINDOW) begin
         eff_len = swm_pkg::LEN_W'(swm_pkg::MAX_WINDOW);
      end else begin
         eff_len = swm_pkg::LEN_W'(window_len_ff);
      end
   end

   assign lo_rank = swm_pkg::IDX_W'((eff_len - 1'b1) >> 1);
   assign hi_rank = swm_pkg::IDX_W'(eff_len >> 1);

   // Cells that hold one of the newest eff_len samples
   always_comb begin
      for (int i = 0; i < swm_pkg::MAX_WINDOW; i++) begin
         active_set[i] = (i + 32'(eff_len)) >= swm_pkg::MAX_WINDOW;
      end
   end

   // Sequencer
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_COUNT;
            step_in  = '0;
         end
         ST_COUNT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == swm_pkg::IDX_W'(swm_pkg::MAX_WINDOW - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
   end

   assign ctl.shift = accept;
   assign ctl.load  = (state_ff == ST_LOAD);
   assign ctl.count = (state_ff == ST_COUNT);

   // Ring of cells
   for (genvar i = 0; i < swm_pkg::MAX_WINDOW; i++) begin : g_cell
      localparam int PREV = (i + swm_pkg::MAX_WINDOW - 1) % swm_pkg::MAX_WINDOW;
      logic signed [swm_pkg::SAMPLE_W-1:0] shift_src;

      if (i == swm_pkg::MAX_WINDOW - 1) begin : g_newest
         assign shift_src = req_sample;
      end else begin : g_inner
         assign shift_src = samples[i+1];
      end

      swm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .my_idx     (swm_pkg::IDX_W'(i)),
         .active_in  (active_set[i]),
         .shift_in   (shift_src),
         .probe_in   (probes[PREV]),
         .sample_out (samples[i]),
         .probe_out  (probes[i]),
         .rank_out   (ranks[i]),
         .active_out (active_cells[i])
      );
   end

   swm_select u_select (
      .samples (samples),
      .ranks   (ranks),
      .active  (active_cells),
      .lo_rank (lo_rank),
      .hi_rank (hi_rank),
      .median  (median)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_median_ff <= median;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule

// ===== src/swm_cell.sv =====
// One window cell: holds a sample, passes probes to its neighbor, counts its rank.
module swm_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  swm_pkg::cell_ctl_type                 ctl,
   input  logic [swm_pkg::IDX_W-1:0]             my_idx,
   input  logic                                  active_in,
   input  logic signed [swm_pkg::SAMPLE_W-1:0]   shift_in,
   input  swm_pkg::probe_type                    probe_in,
   output logic signed [swm_pkg::SAMPLE_W-1:0]   sample_out,
   output swm_pkg::probe_type                    probe_out,
   output logic [swm_pkg::IDX_W-1:0]             rank_out,
   output logic                                  active_out
);

   logic signed [swm_pkg::SAMPLE_W-1:0] sample_ff;
   swm_pkg::probe_type                  probe_ff, probe_next_in;
   logic [swm_pkg::IDX_W-1:0]           rank_ff, rank_in;
   logic                                active_ff;
   logic                                below;

   // Probe ranks below this cell: smaller value, or equal value from a lower cell
   assign below = probe_in.active &&
                  ((probe_in.value < sample_ff) ||
                   ((probe_in.value == sample_ff) && (probe_in.idx < my_idx)));

   always_comb begin
      probe_next_in = probe_ff;
      rank_in       = rank_ff;
      if (ctl.load) begin
         probe_next_in.active = active_in;
         probe_next_in.idx    = my_idx;
         probe_next_in.value  = sample_ff;
         rank_in              = '0;
      end else if (ctl.count) begin
         probe_next_in = probe_in;
         if (below) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   // Window sample: cleared at reset, shifts toward the oldest end on a request
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (ctl.shift) begin
         sample_ff <= shift_in;
      end
   end

   // Ranking registers
   always_ff @(posedge clock) begin
      probe_ff <= probe_next_in;
      rank_ff  <= rank_in;
      if (ctl.load) begin
         active_ff <= active_in;
      end
   end

   assign sample_out = sample_ff;
   assign probe_out  = probe_ff;
   assign rank_out   = rank_ff;
   assign active_out = active_ff;

endmodule

// ===== src/swm_select.sv =====
// Picks the two middle-ranked samples and forms their floored average.
module swm_select (
   input  logic signed [swm_pkg::SAMPLE_W-1:0] samples [swm_pkg::MAX_WINDOW],
   input  logic [swm_pkg::IDX_W-1:0]           ranks   [swm_pkg::MAX_WINDOW],
   input  logic [swm_pkg::MAX_WINDOW-1:0]      active,
   input  logic [swm_pkg::IDX_W-1:0]           lo_rank,
   input  logic [swm_pkg::IDX_W-1:0]           hi_rank,
   output logic signed [swm_pkg::SAMPLE_W-1:0] median
);

   logic [swm_pkg::SAMPLE_W-1:0] lo_val, hi_val;
   logic signed [swm_pkg::SAMPLE_W:0] sum;

   // Ranks are unique among active cells, so an OR of the matches is a select
   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < swm_pkg::MAX_WINDOW; i++) begin
         if (active[i] && (ranks[i] == lo_rank)) begin
            lo_val = lo_val | samples[i];
         end
         if (active[i] && (ranks[i] == hi_rank)) begin
            hi_val = hi_val | samples[i];
         end
      end
   end

   // Odd lengths pick the same sample twice, so the halving returns it unchanged
   assign sum    = $signed({lo_val[swm_pkg::SAMPLE_W-1], lo_val}) +
                   $signed({hi_val[swm_pkg::SAMPLE_W-1], hi_val});
   assign median = sum[swm_pkg::SAMPLE_W:1];

endmodule

// ===== src/swm_checker.sv =====
// Port-level checks for the sliding window median unit, bound to the top level.
module swm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [swm_pkg::SAMPLE_W-1:0]  rsp_median,
   input logic                                 csr_pready
);

   // A stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median))
      else $error("response changed while stalled");

   // Ranking keeps the input closed after a request, through the load state and the first counting step
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request taken while ranking");

   // Reset drops any pending response
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Register port never inserts wait states
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr port stalled");

endmodule

bind sliding_window_median_unit swm_checker u_swm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_median (rsp_median),
   .csr_pready (csr_pready)
);
